// File: sv/grid_step_motion_sequencer_assert.svh
// Assertion macros used by the checker file.
`ifndef GRID_STEP_MOTION_SEQUENCER_ASSERT_SVH
`define GRID_STEP_MOTION_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GSMS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsms: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define GSMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsms: next-cycle check failed");

`endif

// File: sv/gsms_pkg.sv
package gsms_pkg;

  localparam int QUEUE_DEPTH_DEF = 3;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int COORD_W         = 16;
  localparam int DUR_W           = 16;
  localparam int DRIVE_W         = 9;

  localparam logic [7:0] DUTY_MAX      = 8'd255;
  localparam logic [1:0] HEAD_TURN_CW  = 2'd1;
  localparam logic [1:0] HEAD_TURN_CCW = 2'd3;

  // command codes
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_STEP = 3'd1;
  localparam logic [2:0] OP_FWD  = 3'd2;
  localparam logic [2:0] OP_BACK = 3'd3;
  localparam logic [2:0] OP_CW   = 3'd4;
  localparam logic [2:0] OP_CCW  = 3'd5;

  // headings
  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FWD_DUR   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_DUR   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FWD_LEFT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FWD_RIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BCK_LEFT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BCK_RIGHT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_LEFT  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_RIGHT = 3'd7;

  typedef enum logic [2:0] {
    ACT_IDLE = 3'd0,
    ACT_FWD  = 3'd1,
    ACT_BACK = 3'd2,
    ACT_CW   = 3'd3,
    ACT_CCW  = 3'd4
  } action_t;

  typedef struct packed {
    logic [DUR_W-1:0]          fwd_dur;
    logic [DUR_W-1:0]          rot_dur;
    logic signed [DRIVE_W-1:0] fwd_left;
    logic signed [DRIVE_W-1:0] fwd_right;
    logic signed [DRIVE_W-1:0] bck_left;
    logic signed [DRIVE_W-1:0] bck_right;
    logic signed [DRIVE_W-1:0] rot_left;
    logic signed [DRIVE_W-1:0] rot_right;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                operation;
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
  } item_t;

  typedef struct packed {
    logic [2:0] running_action;
    logic [1:0] heading;
    logic       left_reverse;
    logic [7:0] left_duty;
    logic       right_reverse;
    logic [7:0] right_duty;
    logic       all_idle;
    logic       request_taken;
  } result_t;

  typedef struct packed {
    logic       rev;
    logic [7:0] duty;
  } drive_t;

  // Signed drive to direction level and clamped duty.
  function automatic drive_t drive_map(input logic signed [DRIVE_W:0] v);
    logic signed [DRIVE_W:0] mag;
    drive_t d;
    mag   = v[DRIVE_W] ? -v : v;
    d.rev = v[DRIVE_W];
    if (mag > $signed({2'b00, DUTY_MAX})) begin
      d.duty = DUTY_MAX;
    end else begin
      d.duty = mag[7:0];
    end
    return d;
  endfunction

endpackage

// File: sv/gsms_cmd_if.sv
interface gsms_cmd_if import gsms_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                operation;
  logic signed [COORD_W-1:0] from_x;
  logic signed [COORD_W-1:0] from_y;
  logic signed [COORD_W-1:0] to_x;
  logic signed [COORD_W-1:0] to_y;

  modport source (output valid, operation, from_x, from_y, to_x, to_y, input ready);
  modport sink   (input valid, operation, from_x, from_y, to_x, to_y, output ready);
endinterface

// File: sv/gsms_res_if.sv
interface gsms_res_if import gsms_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] running_action;
  logic [1:0] heading;
  logic       left_reverse;
  logic [7:0] left_duty;
  logic       right_reverse;
  logic [7:0] right_duty;
  logic       all_idle;
  logic       request_taken;

  modport source (output valid, running_action, heading, left_reverse, left_duty,
                  right_reverse, right_duty, all_idle, request_taken, input ready);
  modport sink   (input valid, running_action, heading, left_reverse, left_duty,
                  right_reverse, right_duty, all_idle, request_taken, output ready);
endinterface

// File: sv/gsms_cfg_regs.sv
module gsms_cfg_regs import gsms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // register file, all cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FWD_DUR:   cfg.fwd_dur   <= cfg_data[DUR_W-1:0];
        REG_ROT_DUR:   cfg.rot_dur   <= cfg_data[DUR_W-1:0];
        REG_FWD_LEFT:  cfg.fwd_left  <= cfg_data[DRIVE_W-1:0];
        REG_FWD_RIGHT: cfg.fwd_right <= cfg_data[DRIVE_W-1:0];
        REG_BCK_LEFT:  cfg.bck_left  <= cfg_data[DRIVE_W-1:0];
        REG_BCK_RIGHT: cfg.bck_right <= cfg_data[DRIVE_W-1:0];
        REG_ROT_LEFT:  cfg.rot_left  <= cfg_data[DRIVE_W-1:0];
        REG_ROT_RIGHT: cfg.rot_right <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/gsms_core.sv
module gsms_core import gsms_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(QUEUE_DEPTH);

  // machine state
  logic [1:0]       heading;
  action_t          act;
  logic [DUR_W-1:0] ticks;
  action_t          queue [QUEUE_DEPTH];
  logic [CNT_W-1:0] count;
  logic             left_rev, right_rev;
  logic [7:0]       left_duty, right_duty;

  logic [1:0]       heading_next;
  action_t          act_next;
  logic [DUR_W-1:0] ticks_next;
  action_t          queue_next [QUEUE_DEPTH];
  logic [CNT_W-1:0] count_next;
  logic             left_rev_next, right_rev_next;
  logic [7:0]       left_duty_next, right_duty_next;
  logic             taken;

  // working values
  action_t          qa [QUEUE_DEPTH];
  logic [CNT_W-1:0] cnta;
  logic             pop_req;
  logic             start;
  action_t          start_act;
  action_t          man_act;
  logic [DUR_W-1:0] tdec;
  logic signed [COORD_W:0] dx, dy;
  logic             tgt_ok;
  logic [1:0]       tgt, hdiff;
  action_t          seq [3];
  logic [1:0]       seq_n;
  logic [CNT_W-1:0] seq_cnt;
  drive_t           dl, dr;

  // step target from the cell difference
  always_comb begin
    dx = {item.to_x[COORD_W-1], item.to_x} - {item.from_x[COORD_W-1], item.from_x};
    dy = {item.to_y[COORD_W-1], item.to_y} - {item.from_y[COORD_W-1], item.from_y};
    tgt_ok = 1'b1;
    tgt    = HEAD_UP;
    if (dx == (COORD_W+1)'(1) && dy == '0) begin
      tgt = HEAD_RIGHT;
    end else if (dx == '1 && dy == '0) begin
      tgt = HEAD_LEFT;
    end else if (dx == '0 && dy == (COORD_W+1)'(1)) begin
      tgt = HEAD_UP;
    end else if (dx == '0 && dy == '1) begin
      tgt = HEAD_DOWN;
    end else begin
      tgt_ok = 1'b0;
    end
    hdiff = tgt - heading;
    seq[0] = ACT_FWD;
    seq[1] = ACT_FWD;
    seq[2] = ACT_FWD;
    case (hdiff)
      2'd1: begin
        seq[0] = ACT_CW;
        seq_n  = 2'd2;
      end
      2'd3: begin
        seq[0] = ACT_CCW;
        seq_n  = 2'd2;
      end
      2'd2: begin
        seq[0] = ACT_CW;
        seq[1] = ACT_CW;
        seq_n  = 2'd3;
      end
      default: seq_n = 2'd1;
    endcase
    seq_cnt = (CNT_W'(seq_n) < DEPTH) ? CNT_W'(seq_n) : DEPTH;
  end

  // manual command to queued action
  always_comb begin
    case (item.operation)
      OP_FWD:  man_act = ACT_FWD;
      OP_BACK: man_act = ACT_BACK;
      OP_CW:   man_act = ACT_CW;
      OP_CCW:  man_act = ACT_CCW;
      default: man_act = ACT_IDLE;
    endcase
  end

  // next state for one request
  always_comb begin
    heading_next    = heading;
    act_next        = act;
    ticks_next      = ticks;
    left_rev_next   = left_rev;
    right_rev_next  = right_rev;
    left_duty_next  = left_duty;
    right_duty_next = right_duty;
    taken           = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) qa[i] = queue[i];
    cnta      = count;
    pop_req   = 1'b0;
    start_act = ACT_IDLE;
    tdec      = (ticks != '0) ? ticks - DUR_W'(1) : '0;

    case (item.operation)
      OP_TICK: begin
        if (act == ACT_IDLE) begin
          pop_req = (count != '0);
        end else begin
          ticks_next = tdec;
          if (tdec == '0) begin
            left_duty_next  = '0;
            right_duty_next = '0;
            if (act == ACT_CW) begin
              heading_next = heading + HEAD_TURN_CW;
            end else if (act == ACT_CCW) begin
              heading_next = heading + HEAD_TURN_CCW;
            end
            act_next = ACT_IDLE;
            pop_req  = (count != '0);
          end
        end
      end
      OP_STEP: begin
        if (act == ACT_IDLE && count == '0 && tgt_ok) begin
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i < 3) qa[i] = seq[i];
          end
          cnta    = seq_cnt;
          taken   = 1'b1;
          pop_req = 1'b1;
        end
      end
      OP_FWD, OP_BACK, OP_CW, OP_CCW: begin
        if (count < DEPTH) begin
          qa[count[IDX_W-1:0]] = man_act;
          cnta  = count + CNT_W'(1);
          taken = 1'b1;
        end
        pop_req = (act == ACT_IDLE);
      end
      default: ;
    endcase

    // pop the head of the queue into the running slot
    start = pop_req;
    if (pop_req && cnta != '0) begin
      start_act = qa[0];
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) qa[i] = qa[i+1];
      cnta = cnta - CNT_W'(1);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) queue_next[i] = qa[i];
    count_next = cnta;

    // start the popped action
    dl = '0;
    dr = '0;
    if (start) begin
      act_next = start_act;
      case (start_act)
        ACT_FWD: begin
          ticks_next = cfg.fwd_dur;
          dl = drive_map({cfg.fwd_left[DRIVE_W-1], cfg.fwd_left});
          dr = drive_map({cfg.fwd_right[DRIVE_W-1], cfg.fwd_right});
        end
        ACT_BACK: begin
          ticks_next = cfg.fwd_dur;
          dl = drive_map({cfg.bck_left[DRIVE_W-1], cfg.bck_left});
          dr = drive_map({cfg.bck_right[DRIVE_W-1], cfg.bck_right});
        end
        ACT_CW: begin
          ticks_next = cfg.rot_dur;
          dl = drive_map({cfg.rot_left[DRIVE_W-1], cfg.rot_left});
          dr = drive_map({cfg.rot_right[DRIVE_W-1], cfg.rot_right});
        end
        ACT_CCW: begin
          ticks_next = cfg.rot_dur;
          dl = drive_map(-$signed({cfg.rot_left[DRIVE_W-1], cfg.rot_left}));
          dr = drive_map(-$signed({cfg.rot_right[DRIVE_W-1], cfg.rot_right}));
        end
        default: begin
          act_next        = ACT_IDLE;
          ticks_next      = '0;
          left_duty_next  = '0;
          right_duty_next = '0;
        end
      endcase
      if (start_act != ACT_IDLE) begin
        left_rev_next   = dl.rev;
        left_duty_next  = dl.duty;
        right_rev_next  = dr.rev;
        right_duty_next = dr.duty;
      end
    end
  end

  // result of the request, from the updated state
  always_comb begin
    result.running_action = act_next;
    result.heading        = heading_next;
    result.left_reverse   = left_rev_next;
    result.left_duty      = left_duty_next;
    result.right_reverse  = right_rev_next;
    result.right_duty     = right_duty_next;
    result.all_idle       = (act_next == ACT_IDLE) && (count_next == '0);
    result.request_taken  = taken;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      heading    <= HEAD_UP;
      act        <= ACT_IDLE;
      ticks      <= '0;
      count      <= '0;
      left_rev   <= 1'b0;
      right_rev  <= 1'b0;
      left_duty  <= '0;
      right_duty <= '0;
    end else if (fire) begin
      heading    <= heading_next;
      act        <= act_next;
      ticks      <= ticks_next;
      count      <= count_next;
      left_rev   <= left_rev_next;
      right_rev  <= right_rev_next;
      left_duty  <= left_duty_next;
      right_duty <= right_duty_next;
    end
  end

  // queue entries, valid below count only
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) queue[i] <= queue_next[i];
    end
  end

endmodule

// File: sv/grid_step_motion_sequencer.sv
// Grid step motion sequencer for a two-wheel drive.
// cmd channel: one request per item (tick, step request to an adjacent
//   cell, or manual forward / backward / clockwise / counterclockwise).
// res channel: exactly one result per request with the running action,
//   heading, both motor direction levels and duties, an idle flag and
//   whether the request was queued.
// cfg port: eight registers (durations and signed drives); the user writes them by
//   cfg_write / cfg_index / cfg_data only while the block is idle, unchecked by the block.
// A request is taken into the input register and its result is held in
//   the result register on res. Throughput: one request per cycle while res
//   is not held off; the whole update is a single registered pass through the core state logic.
// Stall: when res is held off, the result register keeps its value and
//   one more request is still taken into the input register; cmd.ready
//   drops only while both registers are full.
// Reset (rst, synchronous): heading up, idle, empty queue, duties zero,
//   all cfg registers zero; both channel registers empty.
module grid_step_motion_sequencer import gsms_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  gsms_cmd_if.sink               cmd,
  gsms_res_if.source             res,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_full;
  result_t core_res;
  result_t out_res;
  logic    out_full;
  logic    advance;

  gsms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gsms_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (core_res)
  );

  // request moves into the core when the result slot frees up
  assign advance   = in_full && (!out_full || res.ready);
  assign cmd.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (cmd.ready) begin
        in_full <= cmd.valid;
      end
      if (advance) begin
        out_full <= 1'b1;
      end else if (res.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item.operation <= cmd.operation;
      in_item.from_x    <= cmd.from_x;
      in_item.from_y    <= cmd.from_y;
      in_item.to_x      <= cmd.to_x;
      in_item.to_y      <= cmd.to_y;
    end
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign res.valid          = out_full;
  assign res.running_action = out_res.running_action;
  assign res.heading        = out_res.heading;
  assign res.left_reverse   = out_res.left_reverse;
  assign res.left_duty      = out_res.left_duty;
  assign res.right_reverse  = out_res.right_reverse;
  assign res.right_duty     = out_res.right_duty;
  assign res.all_idle       = out_res.all_idle;
  assign res.request_taken  = out_res.request_taken;

endmodule

// File: sv/gsms_checker.sv
`include "grid_step_motion_sequencer_assert.svh"

module gsms_checker import gsms_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] running_action,
  input logic [1:0] heading,
  input logic       left_reverse,
  input logic [7:0] left_duty,
  input logic       right_reverse,
  input logic [7:0] right_duty,
  input logic       all_idle,
  input logic       request_taken
);

  logic       have_prev;
  logic [2:0] prev_act;
  logic [1:0] prev_heading;
  logic       res_fire;
  logic       prev_turning;

  assign res_fire     = res_valid && res_ready;
  assign prev_turning = (prev_act == ACT_CW) || (prev_act == ACT_CCW);

  // last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (res_fire) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      prev_act     <= running_action;
      prev_heading <= heading;
    end
  end

  // no drive while idle
  `GSMS_ASSERT_IMPL(a_idle_stopped, res_valid && running_action == ACT_IDLE,
                    left_duty == 8'd0 && right_duty == 8'd0)

  // idle flag implies nothing running
  `GSMS_ASSERT_IMPL(a_all_idle, res_valid && all_idle, running_action == ACT_IDLE)

  // heading moves only after a turn was running
  `GSMS_ASSERT_IMPL(a_heading_hold, res_fire && have_prev && !prev_turning,
                    heading == prev_heading)

  // stalled result holds
  `GSMS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
                    res_valid && $stable(running_action) && $stable(heading) &&
                    $stable(left_reverse) && $stable(left_duty) &&
                    $stable(right_reverse) && $stable(right_duty) &&
                    $stable(all_idle) && $stable(request_taken))

endmodule

bind grid_step_motion_sequencer gsms_checker u_gsms_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .running_action (res.running_action),
  .heading        (res.heading),
  .left_reverse   (res.left_reverse),
  .left_duty      (res.left_duty),
  .right_reverse  (res.right_reverse),
  .right_duty     (res.right_duty),
  .all_idle       (res.all_idle),
  .request_taken  (res.request_taken)
);
